// ===== rtl/core/alurf_pkg.sv =====
// Package with the shared types and function codes of the ALU with register file.
`default_nettype none

package alurf_pkg;

	localparam int unsigned REG_COUNT = 8;
	localparam int unsigned REG_AW    = 3;
	localparam int unsigned WORD_W    = 16;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [REG_AW-1:0] reg_idx_t;

	// Function select for one instruction
	typedef struct packed {
		logic       mode;
		logic [3:0] select;
	} alurf_op_t;

	localparam logic MODE_ARITH = 1'b0;
	localparam logic MODE_LOGIC = 1'b1;

	// Arithmetic functions (mode 0), 74181 table order
	localparam logic [3:0] AR_A            = 4'd0;
	localparam logic [3:0] AR_A_OR_B       = 4'd1;
	localparam logic [3:0] AR_A_OR_NB      = 4'd2;
	localparam logic [3:0] AR_ONES         = 4'd3;
	localparam logic [3:0] AR_A_PL_ANB     = 4'd4;
	localparam logic [3:0] AR_AOB_PL_ANB   = 4'd5;
	localparam logic [3:0] AR_A_MI_B_MI1   = 4'd6;
	localparam logic [3:0] AR_ANB_MI1      = 4'd7;
	localparam logic [3:0] AR_A_PL_AB      = 4'd8;
	localparam logic [3:0] AR_A_PL_B       = 4'd9;
	localparam logic [3:0] AR_AONB_PL_AB   = 4'd10;
	localparam logic [3:0] AR_AB_MI1       = 4'd11;
	localparam logic [3:0] AR_A_PL_A       = 4'd12;
	localparam logic [3:0] AR_AOB_PL_A     = 4'd13;
	localparam logic [3:0] AR_AONB_PL_A    = 4'd14;
	localparam logic [3:0] AR_A_MI1        = 4'd15;

	// Logic functions (mode 1), 74181 table order
	localparam logic [3:0] LG_NA           = 4'd0;
	localparam logic [3:0] LG_NOR          = 4'd1;
	localparam logic [3:0] LG_NA_AND_B     = 4'd2;
	localparam logic [3:0] LG_ZEROS        = 4'd3;
	localparam logic [3:0] LG_NAND         = 4'd4;
	localparam logic [3:0] LG_NB           = 4'd5;
	localparam logic [3:0] LG_XOR          = 4'd6;
	localparam logic [3:0] LG_A_AND_NB     = 4'd7;
	localparam logic [3:0] LG_NA_OR_B      = 4'd8;
	localparam logic [3:0] LG_XNOR         = 4'd9;
	localparam logic [3:0] LG_B            = 4'd10;
	localparam logic [3:0] LG_AND          = 4'd11;
	localparam logic [3:0] LG_ONES         = 4'd12;
	localparam logic [3:0] LG_A_OR_NB      = 4'd13;
	localparam logic [3:0] LG_OR           = 4'd14;
	localparam logic [3:0] LG_A            = 4'd15;

endpackage

`default_nettype wire

// ===== rtl/core/alurf_alu.sv =====
// 16-bit ALU with the 74181 function table, no carry in.
`default_nettype none

module alurf_alu
	import alurf_pkg::*;
(
	input  alurf_op_t op,
	input  word_t     a,
	input  word_t     b,
	output word_t     y
);

	word_t nb;
	word_t r;

	always_comb begin
		nb = ~b;
		r  = '0;
		if (op.mode == MODE_ARITH) begin
			case (op.select)
				AR_A:          r = a;
				AR_A_OR_B:     r = a | b;
				AR_A_OR_NB:    r = a | nb;
				AR_ONES:       r = '1;
				AR_A_PL_ANB:   r = a + (a & nb);
				AR_AOB_PL_ANB: r = (a | b) + (a & nb);
				AR_A_MI_B_MI1: r = a - b - word_t'(1);
				AR_ANB_MI1:    r = (a & nb) - word_t'(1);
				AR_A_PL_AB:    r = a + (a & b);
				AR_A_PL_B:     r = a + b;
				AR_AONB_PL_AB: r = (a | nb) + (a & b);
				AR_AB_MI1:     r = (a & b) - word_t'(1);
				AR_A_PL_A:     r = a + a;
				AR_AOB_PL_A:   r = (a | b) + a;
				AR_AONB_PL_A:  r = (a | nb) + a;
				AR_A_MI1:      r = a - word_t'(1);
				default:       r = a;
			endcase
		end else begin
			case (op.select)
				LG_NA:         r = ~a;
				LG_NOR:        r = ~(a | b);
				LG_NA_AND_B:   r = ~a & b;
				LG_ZEROS:      r = '0;
				LG_NAND:       r = ~(a & b);
				LG_NB:         r = nb;
				LG_XOR:        r = a ^ b;
				LG_A_AND_NB:   r = a & nb;
				LG_NA_OR_B:    r = ~a | b;
				LG_XNOR:       r = ~(a ^ b);
				LG_B:          r = b;
				LG_AND:        r = a & b;
				LG_ONES:       r = '1;
				LG_A_OR_NB:    r = a | nb;
				LG_OR:         r = a | b;
				LG_A:          r = a;
				default:       r = a;
			endcase
		end
	end

	assign y = r;

endmodule

`default_nettype wire

// ===== rtl/core/alu_with_register_file.sv =====
// Top level: register file memory, operand forwarding, ALU stage and output register.
`default_nettype none

// Channel  Direction  Handshake            Payload
// in       to block   in_valid / in_stall  reg_a[2:0] reg_b[2:0] alu_mode alu_select[3:0]
// out      from block out_valid/out_stall  result[15:0]
//
// One instruction per cycle sustained while out is not stalled. The accepting edge
// captures the memory read and instruction fields into stage 1; when stage 1 advances,
// the ALU result is written back and loaded into the output register, raising out_valid.
// The register file is an 8 x 16 memory with two synchronous read ports and one
// write port; a per-entry valid bit, cleared by reset, makes unwritten registers
// read as zero, so the block takes transactions right after reset.
// A write-back that lands in the same edge as the next read is forwarded.
// When out is stalled with a result waiting, hold the ALU stage and stall the input.

module alu_with_register_file
	import alurf_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [REG_AW-1:0]   reg_a,
	input  wire logic [REG_AW-1:0]   reg_b,
	input  wire logic                alu_mode,
	input  wire logic [3:0]          alu_select,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [WORD_W-1:0]        result
);

	// Register file storage and per-entry written flags
	word_t                mem [REG_COUNT];
	logic [REG_COUNT-1:0] written_q;

	// Stage 1: read data from memory plus instruction fields
	logic       valid_s1;
	reg_idx_t   reg_a_s1;
	reg_idx_t   reg_b_s1;
	alurf_op_t  op_s1;
	word_t      rd_a_s1;
	word_t      rd_b_s1;
	logic       wr_a_s1;
	logic       wr_b_s1;

	// Last write-back, for forwarding to a read issued in the same edge
	logic       lw_valid_q;
	reg_idx_t   lw_addr_q;
	word_t      lw_data_q;

	// Output register
	logic       out_valid_q;
	word_t      result_q;

	logic       in_accept;
	logic       adv_s1;
	word_t      opa;
	word_t      opb;
	word_t      alu_y;
	alurf_op_t  op_in;

	// Advance stage 1 when the output register is free or being emptied
	assign adv_s1    = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv_s1;
	assign in_accept = in_valid && !in_stall;

	assign op_in.mode   = alu_mode;
	assign op_in.select = alu_select;

	// Operand select: forward last write, else memory, else reset value zero
	always_comb begin
		if (lw_valid_q && (lw_addr_q == reg_a_s1)) begin
			opa = lw_data_q;
		end else if (wr_a_s1) begin
			opa = rd_a_s1;
		end else begin
			opa = '0;
		end
		if (lw_valid_q && (lw_addr_q == reg_b_s1)) begin
			opb = lw_data_q;
		end else if (wr_b_s1) begin
			opb = rd_b_s1;
		end else begin
			opb = '0;
		end
	end

	alurf_alu u_alu (
		.op (op_s1),
		.a  (opa),
		.b  (opb),
		.y  (alu_y)
	);

	// Memory: two registered read ports, one write port (no reset on storage)
	always_ff @(posedge clk) begin
		if (in_accept) begin
			rd_a_s1 <= mem[reg_a];
			rd_b_s1 <= mem[reg_b];
		end
		if (adv_s1) begin
			mem[reg_a_s1] <= alu_y;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			reg_a_s1 <= reg_a;
			reg_b_s1 <= reg_b;
			op_s1    <= op_in;
		end
	end

	// Control: stage valid, written flags, last-write tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			wr_a_s1    <= 1'b0;
			wr_b_s1    <= 1'b0;
			written_q  <= '0;
			lw_valid_q <= 1'b0;
			lw_addr_q  <= '0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
				wr_a_s1  <= written_q[reg_a];
				wr_b_s1  <= written_q[reg_b];
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				written_q[reg_a_s1] <= 1'b1;
				lw_valid_q          <= 1'b1;
				lw_addr_q           <= reg_a_s1;
			end
		end
	end

	// Last-write data and output payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			lw_data_q <= alu_y;
			result_q  <= alu_y;
		end
	end

	// Output valid: set on advance, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

	// Every stage-1 advance presents a result in the next cycle
	a_adv_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> out_valid_q)
		else $error("stage advance did not present a result");

	// Input is stalled only with stage 1 full and blocked by the output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked stage");

	// Write-back is tracked for forwarding at the destination register
	a_fwd_track: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> (lw_valid_q && (lw_addr_q == $past(reg_a_s1))
			&& written_q[$past(reg_a_s1)]))
		else $error("write-back not recorded for forwarding");

	// A held result keeps its value while out is stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(result_q)))
		else $error("stalled result changed");

endmodule

`default_nettype wire
